// ===== hw/rtl/taa_pkg.sv =====
// shared types and constants for the timestamp aligned aggregator
package taa_pkg;
    localparam int PortsDefault = 4;
    localparam int QueueDepthDefault = 16;
    localparam int MaxResults = 64;
    localparam int TimeW = 48;
    localparam int ValW = 32;
    localparam logic [2:0] FnSum = 3'd0;
    localparam logic [2:0] FnAvg = 3'd1;
    localparam logic [2:0] FnCount = 3'd2;
    localparam logic [2:0] FnMin = 3'd3;
    localparam logic [2:0] FnMax = 3'd4;
    localparam logic CmdPush = 1'b0;
    localparam logic CmdClose = 1'b1;
    localparam logic RegFunction = 1'b0;
    localparam logic RegActive = 1'b1;
    localparam logic signed [ValW-1:0] PositiveInfinity = 32'sh7fffffff;
    localparam logic signed [ValW-1:0] NegativeInfinity = 32'sh80000000;

    typedef struct packed {
        logic             cmd;
        logic [1:0]       port;
        logic [TimeW-1:0] ts;
        logic [ValW-1:0]  val;
    } t_item;

    typedef enum logic [2:0] {
        S_IDLE, S_APPLY, S_READ, S_SCAN, S_POP, S_DIV, S_EMIT
    } t_state;
endpackage

// ===== hw/rtl/taa_ram.sv =====
// generic single port write, single port registered read ram
module taa_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== hw/rtl/taa_front.sv =====
// command front: takes items and holds them in a short queue
module taa_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_take,
    input  taa_pkg::t_item i_item,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_avail,
    output taa_pkg::t_item o_item
);
    import taa_pkg::*;
    t_item r_q [2];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;
    assign o_full = r_cnt == 2'd2;
    assign o_avail = r_cnt != 2'd0;
    assign o_item = r_q[r_rp];
    always_ff @(posedge i_clk) begin
        if (i_take) r_q[r_wp] <= i_item;
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_take) r_wp <= ~r_wp;
            if (i_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, i_take} - {1'b0, i_pop};
        end
    end
endmodule

// ===== hw/rtl/taa_back.sv =====
// merge engine: per-port fifos, head scan, aggregation and result output
module taa_back #(
    parameter int PORTS = taa_pkg::PortsDefault,
    parameter int QUEUE_DEPTH = taa_pkg::QueueDepthDefault
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_avail,
    input  taa_pkg::t_item               i_item,
    output logic                         o_pop,
    input  logic [2:0]                   i_fn,
    input  logic [2:0]                   i_active,
    output logic                         o_valid,
    output logic [taa_pkg::TimeW-1:0]    o_out_time,
    output logic signed [taa_pkg::ValW-1:0] o_out_value,
    output logic                         o_saturated,
    output logic                         o_all_finished,
    output logic                         o_last_of_run
);
    import taa_pkg::*;
    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int PW = (PORTS > 1) ? $clog2(PORTS) : 1;
    localparam int FW = $clog2(QUEUE_DEPTH + 1);
    localparam int CW = $clog2(PORTS + 1);
    localparam int RW = $clog2(MaxResults + 1);
    localparam int SW = ValW + 4;

    t_state r_st, n_st;
    logic [AW-1:0] r_rd [PORTS];
    logic [FW-1:0] r_fill [PORTS];
    logic [PORTS-1:0] r_closed;
    logic [TimeW-1:0] head_t [PORTS];
    logic [ValW-1:0] head_v [PORTS];
    logic [PW:0] r_p;
    logic r_found;
    logic [TimeW-1:0] r_tmin;
    logic signed [SW-1:0] r_acc;
    logic signed [ValW-1:0] r_lo, r_hi;
    logic [CW-1:0] r_taken;
    logic [RW-1:0] r_cnt;
    logic [SW-1:0] r_rem, r_quo;
    logic [5:0] r_bit;
    logic r_neg;

    logic [3:0] n_live;
    logic [PORTS-1:0] live, ready_v, fin_v;
    always_comb begin
        n_live = ({1'b0, i_active} > 4'(PORTS)) ? 4'(PORTS) : {1'b0, i_active};
        for (int p = 0; p < PORTS; p++) begin
            live[p] = 4'(p) < n_live;
            ready_v[p] = !live[p] || r_fill[p] != '0 || r_closed[p];
            fin_v[p] = !live[p] || (r_fill[p] == '0 && r_closed[p]);
        end
    end
    logic any_data;
    always_comb begin
        any_data = 1'b0;
        for (int p = 0; p < PORTS; p++) any_data |= live[p] && r_fill[p] != '0;
    end

    logic push_ok;
    logic [PW-1:0] ip;
    assign ip = PW'(i_item.port);
    assign push_ok = r_st == S_APPLY && {2'b0, i_item.port} < n_live
        && i_item.cmd == CmdPush && !r_closed[ip] && r_fill[ip] < FW'(QUEUE_DEPTH);

    for (genvar g = 0; g < PORTS; g++) begin : g_q
        logic [AW:0] wsum;
        logic [AW-1:0] wa;
        // tail slot wraps at the queue depth
        assign wsum = {1'b0, r_rd[g]} + (AW+1)'(r_fill[g]);
        assign wa = (wsum >= (AW+1)'(QUEUE_DEPTH)) ? AW'(wsum - (AW+1)'(QUEUE_DEPTH))
                                                    : AW'(wsum);
        taa_ram #(.Width(TimeW), .Depth(QUEUE_DEPTH)) u_t (
            .i_clk(i_clk), .i_we(push_ok && ip == PW'(g)), .i_waddr(wa),
            .i_wdata(i_item.ts), .i_raddr(r_rd[g]), .o_rdata(head_t[g]));
        taa_ram #(.Width(ValW), .Depth(QUEUE_DEPTH)) u_v (
            .i_clk(i_clk), .i_we(push_ok && ip == PW'(g)), .i_waddr(wa),
            .i_wdata(i_item.val), .i_raddr(r_rd[g]), .o_rdata(head_v[g]));
    end

    logic [PW-1:0] cp;
    logic cur_has;
    logic signed [ValW-1:0] cv;
    assign cp = r_p[PW-1:0];
    assign cur_has = live[cp] && r_fill[cp] != '0;
    assign cv = signed'(head_v[cp]);
    logic [2:0] fn;
    assign fn = (i_fn > FnMax) ? FnAvg : i_fn;

    // running sum including the head taken in this pop cycle
    logic take_cur;
    logic signed [ValW-1:0] add_v;
    logic signed [SW-1:0] acc_next;
    assign take_cur = cur_has && head_t[cp] == r_tmin;
    assign add_v = take_cur ? cv : '0;
    assign acc_next = r_acc + SW'(add_v);

    logic signed [SW-1:0] cnt_q;
    assign cnt_q = SW'(r_taken) <<< 16;
    logic signed [SW-1:0] sel;
    assign sel = (fn == FnSum) ? r_acc : cnt_q;
    logic [SW-1:0] trial;
    assign trial = {r_rem[SW-2:0], r_quo[SW-1]};

    assign o_pop = r_st == S_APPLY;

    always_comb begin
        n_st = r_st;
        case (r_st)
            S_IDLE: if (i_avail) n_st = S_APPLY;
            S_APPLY: n_st = S_READ;
            S_READ: n_st = (ready_v == '1 && any_data && r_cnt < RW'(MaxResults))
                ? S_SCAN : S_IDLE;
            S_SCAN: if (r_p == (PW+1)'(PORTS - 1)) n_st = S_POP;
            S_POP: if (r_p == (PW+1)'(PORTS - 1)) n_st = (fn == FnAvg) ? S_DIV : S_EMIT;
            S_DIV: if (r_bit == 6'd0) n_st = S_EMIT;
            S_EMIT: n_st = S_READ;
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        o_valid <= 1'b0;
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_closed <= '0;
            for (int p = 0; p < PORTS; p++) begin
                r_rd[p] <= '0;
                r_fill[p] <= '0;
            end
        end else begin
            r_st <= n_st;
            case (r_st)
                S_APPLY: begin
                    r_cnt <= '0;
                    if ({2'b0, i_item.port} < n_live && i_item.cmd == CmdClose)
                        r_closed[ip] <= 1'b1;
                    if (push_ok) r_fill[ip] <= r_fill[ip] + 1'b1;
                end
                S_READ: begin
                    r_p <= '0;
                    r_found <= 1'b0;
                    r_acc <= '0;
                    r_lo <= PositiveInfinity;
                    r_hi <= NegativeInfinity;
                    r_taken <= '0;
                end
                S_SCAN: begin
                    if (cur_has && (!r_found || head_t[cp] < r_tmin)) begin
                        r_tmin <= head_t[cp];
                        r_found <= 1'b1;
                    end
                    r_p <= (r_p == (PW+1)'(PORTS - 1)) ? '0 : r_p + 1'b1;
                end
                S_POP: begin
                    if (take_cur) begin
                        r_rd[cp] <= (r_rd[cp] == AW'(QUEUE_DEPTH - 1)) ? '0
                                                                        : r_rd[cp] + 1'b1;
                        r_fill[cp] <= r_fill[cp] - 1'b1;
                        r_acc <= acc_next;
                        if (cv < r_lo) r_lo <= cv;
                        if (cv > r_hi) r_hi <= cv;
                        r_taken <= r_taken + 1'b1;
                    end
                    r_p <= r_p + 1'b1;
                    r_neg <= acc_next < 0;
                    r_quo <= (acc_next < 0) ? SW'(-acc_next) : SW'(acc_next);
                    r_rem <= '0;
                    r_bit <= 6'(SW - 1);
                end
                S_DIV: begin
                    // restoring division, one quotient bit a cycle
                    if (trial >= SW'(r_taken)) begin
                        r_rem <= trial - SW'(r_taken);
                        r_quo <= {r_quo[SW-2:0], 1'b1};
                    end else begin
                        r_rem <= trial;
                        r_quo <= {r_quo[SW-2:0], 1'b0};
                    end
                    r_bit <= r_bit - 1'b1;
                end
                S_EMIT: begin
                    o_valid <= 1'b1;
                    r_cnt <= r_cnt + 1'b1;
                    o_out_time <= r_tmin;
                    o_saturated <= 1'b0;
                    o_all_finished <= fin_v == '1;
                    o_last_of_run <= !(ready_v == '1 && any_data
                        && r_cnt + 1'b1 < RW'(MaxResults));
                    case (fn)
                        FnSum, FnCount: begin
                            if (sel > SW'(PositiveInfinity)) begin
                                o_out_value <= PositiveInfinity;
                                o_saturated <= 1'b1;
                            end else if (sel < SW'(NegativeInfinity)) begin
                                o_out_value <= NegativeInfinity;
                                o_saturated <= 1'b1;
                            end else o_out_value <= ValW'(sel);
                        end
                        FnMin: o_out_value <= r_lo;
                        FnMax: o_out_value <= r_hi;
                        default: o_out_value <= r_neg ? ValW'(-signed'(r_quo)) : ValW'(r_quo);
                    endcase
                end
                default: ;
            endcase
        end
    end
endmodule

// ===== hw/rtl/timestamp_aligned_aggregator.sv =====
// top level of the timestamp aligned aggregator
// usage
// - item channel: start with busy low is a transfer of one push or close
//   command; busy rises when the two-entry command queue is full
// - config: write enable, index and data; write only while idle
// - results: o_valid strobes one cycle per result; cannot be stalled
// - an item that releases nothing takes the engine through idle, apply
//   and the readiness check
// - each result takes a readiness check, a head scan and a pop sweep over
//   every port and an emit, plus a bit-serial divider for an average
// - one item may cause up to 64 results, the last flagged last_of_run
// - reset clears fills, pointers and closed flags, function to average
//   and active ports to four
// - queue contents are not cleared at reset
module timestamp_aligned_aggregator #(
    parameter int PORTS = taa_pkg::PortsDefault,
    parameter int QUEUE_DEPTH = taa_pkg::QueueDepthDefault
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic                            i_cfg_we,
    input  logic                            i_cfg_index,
    input  logic [2:0]                      i_cfg_data,
    input  logic                            i_command,
    input  logic [1:0]                      i_port_index,
    input  logic [taa_pkg::TimeW-1:0]       i_time_stamp,
    input  logic signed [taa_pkg::ValW-1:0] i_sample_value,
    output logic                            o_valid,
    output logic [taa_pkg::TimeW-1:0]       o_out_time,
    output logic signed [taa_pkg::ValW-1:0] o_out_value,
    output logic                            o_saturated,
    output logic                            o_all_finished,
    output logic                            o_last_of_run
);
    import taa_pkg::*;
    logic [2:0] r_fn, r_active;
    logic full, avail, pop;
    t_item item_in, item_q;

    assign busy = full;
    assign item_in = '{cmd: i_command, port: i_port_index, ts: i_time_stamp,
                       val: i_sample_value};

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fn <= FnAvg;
            r_active <= 3'd4;
        end else if (i_cfg_we) begin
            if (i_cfg_index == RegFunction) r_fn <= i_cfg_data;
            else r_active <= i_cfg_data;
        end
    end

    taa_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_take(start && !busy),
        .i_item(item_in), .i_pop(pop), .o_full(full), .o_avail(avail),
        .o_item(item_q));

    taa_back #(.PORTS(PORTS), .QUEUE_DEPTH(QUEUE_DEPTH)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_avail(avail), .i_item(item_q),
        .o_pop(pop), .i_fn(r_fn), .i_active(r_active),
        .o_valid(o_valid), .o_out_time(o_out_time), .o_out_value(o_out_value),
        .o_saturated(o_saturated), .o_all_finished(o_all_finished),
        .o_last_of_run(o_last_of_run));
endmodule

// ===== test/tb_timestamp_aligned_aggregator.sv =====
// self-checking testbench for the timestamp aligned aggregator
`timescale 1ns / 1ps

module tb_timestamp_aligned_aggregator;
    import taa_pkg::*;

    localparam int Depth = QueueDepthDefault;
    localparam int SettleCycles = 300;   // covers queued items that make no result
    localparam int StallLimit = 20000;   // cycles with no transfer before giving up
    localparam int RandomItems = 500;

    typedef struct {
        logic [TimeW-1:0]       t;
        logic signed [ValW-1:0] v;
        bit                     sat;
        bit                     fin;
        bit                     last;
    } t_result;

    typedef enum bit {ROW_ITEM, ROW_CFG} t_row_kind;

    typedef struct {
        t_row_kind              kind;
        logic                   cmd;
        logic [1:0]             port;
        logic [TimeW-1:0]       ts;
        logic signed [ValW-1:0] val;
        logic                   reg_idx;
        logic [2:0]             reg_data;
        bit                     typed;
        t_result                res;
    } t_row;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   start;
    logic                   busy;
    logic                   i_cfg_we;
    logic                   i_cfg_index;
    logic [2:0]             i_cfg_data;
    logic                   i_command;
    logic [1:0]             i_port_index;
    logic [TimeW-1:0]       i_time_stamp;
    logic signed [ValW-1:0] i_sample_value;
    logic                   o_valid;
    logic [TimeW-1:0]       o_out_time;
    logic signed [ValW-1:0] o_out_value;
    logic                   o_saturated;
    logic                   o_all_finished;
    logic                   o_last_of_run;

    // predictor state: per-port fifos, closed flags and register copies
    logic [TimeW-1:0]       mq_time [4][Depth];
    logic signed [ValW-1:0] mq_val [4][Depth];
    int                     mq_rd [4];
    int                     mq_fill [4];
    bit                     mq_closed [4];
    logic [2:0]             agg_fn;
    logic [2:0]             agg_active;

    t_result                pending_results [$];
    t_row                   stim_table [$];
    int                     error_count;
    int                     stall_count;
    int                     last_made;
    bit                     no_gaps;
    logic [TimeW-1:0]       last_time [4];

    timestamp_aligned_aggregator dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_command      (i_command),
        .i_port_index   (i_port_index),
        .i_time_stamp   (i_time_stamp),
        .i_sample_value (i_sample_value),
        .o_valid        (o_valid),
        .o_out_time     (o_out_time),
        .o_out_value    (o_out_value),
        .o_saturated    (o_saturated),
        .o_all_finished (o_all_finished),
        .o_last_of_run  (o_last_of_run)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        error_count++;
    endtask

    // merge one command into the fifos and queue every aggregate it releases
    function automatic void merge_and_aggregate(input logic cmd, input logic [1:0] port,
                                                input logic [TimeW-1:0] ts,
                                                input logic signed [ValW-1:0] val);
        int n;
        int made;
        int slot;
        int taken;
        bit found;
        bit ready;
        bit done;
        logic [2:0] fn;
        logic [TimeW-1:0] tmin;
        logic [TimeW-1:0] head;
        longint acc;
        longint lo;
        longint hi;
        longint x;
        t_result r;
        n = (agg_active > 4) ? 4 : int'(agg_active);
        fn = (agg_fn > FnMax) ? FnAvg : agg_fn;
        if (port < n) begin
            if (cmd == CmdClose) begin
                mq_closed[port] = 1'b1;
            end else if (!mq_closed[port] && mq_fill[port] < Depth) begin
                slot = (mq_rd[port] + mq_fill[port]) % Depth;
                mq_time[port][slot] = ts;
                mq_val[port][slot] = val;
                mq_fill[port]++;
            end
        end
        made = 0;
        while (made < MaxResults) begin
            // every active port must hold data or be closed
            ready = 1'b1;
            for (int p = 0; p < n; p++)
                if (mq_fill[p] == 0 && !mq_closed[p]) ready = 1'b0;
            if (!ready) break;
            found = 1'b0;
            tmin = '0;
            for (int p = 0; p < n; p++) begin
                if (mq_fill[p] != 0) begin
                    head = mq_time[p][mq_rd[p]];
                    if (!found || head < tmin) begin
                        tmin = head;
                        found = 1'b1;
                    end
                end
            end
            if (!found) break;
            acc = 0;
            lo = longint'(PositiveInfinity);
            hi = longint'(NegativeInfinity);
            taken = 0;
            r.sat = 1'b0;
            for (int p = 0; p < n; p++) begin
                if (mq_fill[p] != 0 && mq_time[p][mq_rd[p]] == tmin) begin
                    x = longint'(mq_val[p][mq_rd[p]]);
                    mq_rd[p] = (mq_rd[p] + 1) % Depth;
                    mq_fill[p]--;
                    acc += x;
                    if (x < lo) lo = x;
                    if (x > hi) hi = x;
                    taken++;
                end
            end
            if (fn == FnCount) acc = longint'(taken) * 65536;
            case (fn)
                FnSum, FnCount: begin
                    if (acc > longint'(PositiveInfinity)) begin
                        acc = longint'(PositiveInfinity);
                        r.sat = 1'b1;
                    end else if (acc < longint'(NegativeInfinity)) begin
                        acc = longint'(NegativeInfinity);
                        r.sat = 1'b1;
                    end
                end
                FnMin: acc = lo;
                FnMax: acc = hi;
                default: acc = acc / longint'(taken);  // truncates toward zero
            endcase
            done = 1'b1;
            for (int p = 0; p < n; p++)
                if (mq_fill[p] != 0 || !mq_closed[p]) done = 1'b0;
            r.t = tmin;
            r.v = acc[ValW-1:0];
            r.fin = done;
            r.last = 1'b0;
            pending_results.insert(pending_results.size(), r);
            made++;
        end
        if (made > 0) pending_results[$].last = 1'b1;
        last_made = made;
    endfunction

    // one transfer; start stays high afterwards so back-to-back items need no gap
    task automatic send_item(input logic cmd, input logic [1:0] port,
                             input logic [TimeW-1:0] ts, input logic signed [ValW-1:0] val);
        start <= 1'b1;
        i_command <= cmd;
        i_port_index <= port;
        i_time_stamp <= ts;
        i_sample_value <= val;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        merge_and_aggregate(cmd, port, ts, val);
    endtask

    task automatic maybe_gap();
        if (!no_gaps && $urandom_range(0, 99) < 37) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
    endtask

    // wait for the block to drain before touching a register
    task automatic write_register(input logic idx, input logic [2:0] data);
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SettleCycles) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == RegFunction) agg_fn = data;
        else agg_active = data;
    endtask

    function automatic void add_item(input logic cmd, input logic [1:0] port,
                                     input logic [TimeW-1:0] ts,
                                     input logic signed [ValW-1:0] val);
        t_row row;
        row.kind = ROW_ITEM;
        row.cmd = cmd;
        row.port = port;
        row.ts = ts;
        row.val = val;
        row.typed = 1'b0;
        stim_table.insert(stim_table.size(), row);
    endfunction

    function automatic void add_cfg(input logic idx, input logic [2:0] data);
        t_row row;
        row.kind = ROW_CFG;
        row.reg_idx = idx;
        row.reg_data = data;
        row.typed = 1'b0;
        stim_table.insert(stim_table.size(), row);
    endfunction

    // typed expectation: the item must release exactly this one aggregate
    function automatic void add_typed(input logic [TimeW-1:0] t, input logic signed [ValW-1:0] v,
                                      input bit sat, input bit fin);
        stim_table[$].typed = 1'b1;
        stim_table[$].res = '{t: t, v: v, sat: sat, fin: fin, last: 1'b1};
    endfunction

    // result checker: the receiver cannot stall, so every strobe is a transfer
    always @(posedge i_clk) begin
        t_result e;
        if (i_rst_n && o_valid) begin
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result time %h value %h",
                                          o_out_time, o_out_value));
            end else begin
                e = pending_results.pop_front();
                if (o_out_time !== e.t)
                    report_mismatch($sformatf("out_time %h, expected %h", o_out_time, e.t));
                if (o_out_value !== e.v)
                    report_mismatch($sformatf("out_value %h, expected %h", o_out_value, e.v));
                if (o_saturated !== e.sat)
                    report_mismatch($sformatf("saturated %b, expected %b", o_saturated, e.sat));
                if (o_all_finished !== e.fin)
                    report_mismatch($sformatf("all_finished %b, expected %b",
                                              o_all_finished, e.fin));
                if (o_last_of_run !== e.last)
                    report_mismatch($sformatf("last_of_run %b, expected %b",
                                              o_last_of_run, e.last));
            end
        end
    end

    // watchdog on cycles with no transfer in either direction
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) begin
            stall_count <= 0;
        end else begin
            stall_count <= stall_count + 1;
            if (stall_count >= StallLimit) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    initial begin
        int items;
        int n;
        logic [1:0] port;
        logic [TimeW-1:0] ts;
        logic signed [ValW-1:0] val;
        logic cmd;
        logic [2:0] fn_pick;

        error_count = 0;
        stall_count = 0;
        last_made = 0;
        no_gaps = 1'b0;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = 1'b0;
        i_cfg_data = '0;
        i_command = CmdPush;
        i_port_index = '0;
        i_time_stamp = '0;
        i_sample_value = '0;
        for (int p = 0; p < 4; p++) begin
            mq_rd[p] = 0;
            mq_fill[p] = 0;
            mq_closed[p] = 1'b0;
            last_time[p] = '0;
        end
        agg_fn = FnAvg;
        agg_active = 3'd4;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part, reset settings first: average over four ports
        add_item(CmdPush, 2'd0, 48'd0, 32'sh7fffffff);
        add_item(CmdPush, 2'd1, 48'd0, 32'sh7fffffff);
        add_item(CmdPush, 2'd2, 48'd0, 32'sh80000000);
        add_item(CmdPush, 2'd3, 48'd5, 32'sh0);
        add_typed(48'd0, 32'sd715827882, 1'b0, 1'b0);
        add_cfg(RegFunction, FnSum);
        add_item(CmdPush, 2'd0, 48'd10, 32'sh7fffffff);
        add_item(CmdPush, 2'd1, 48'd10, 32'sh7fffffff);
        add_item(CmdPush, 2'd2, 48'd10, 32'sh1);
        // closing port three releases the saturating sum at time ten
        add_item(CmdClose, 2'd3, 48'd0, 32'sh0);
        add_typed(48'd10, 32'sh7fffffff, 1'b1, 1'b0);
        add_item(CmdClose, 2'd3, 48'd0, 32'sh0);          // closing twice
        add_item(CmdPush, 2'd3, 48'd0, 32'sh0);           // push to a closed port
        add_cfg(RegFunction, FnCount);
        add_item(CmdPush, 2'd0, 48'hffffffffffff, 32'sh12345678);
        add_item(CmdPush, 2'd1, 48'hffffffffffff, 32'shedcba987);
        add_item(CmdPush, 2'd2, 48'hffffffffffff, 32'sh0);
        add_typed(48'hffffffffffff, 32'sd196608, 1'b0, 1'b0);
        add_cfg(RegFunction, FnMin);
        add_item(CmdPush, 2'd0, 48'd1, 32'sh80000000);   // times go backwards here
        add_item(CmdPush, 2'd1, 48'd1, 32'sh5);
        add_item(CmdPush, 2'd2, 48'd2, -32'sd1);
        add_cfg(RegFunction, FnMax);
        add_item(CmdPush, 2'd0, 48'd2, 32'sh7fffffff);
        add_item(CmdPush, 2'd1, 48'd3, 32'sh0);
        add_cfg(RegActive, 3'd0);                         // no port active
        add_item(CmdPush, 2'd0, 48'd3, 32'sh1);
        add_cfg(RegActive, 3'd7);                         // acts as four
        add_item(CmdPush, 2'd2, 48'd3, 32'sh2);

        foreach (stim_table[i]) begin
            if (stim_table[i].kind == ROW_CFG) begin
                write_register(stim_table[i].reg_idx, stim_table[i].reg_data);
            end else begin
                send_item(stim_table[i].cmd, stim_table[i].port,
                          stim_table[i].ts, stim_table[i].val);
                if (stim_table[i].typed) begin
                    repeat (last_made) void'(pending_results.pop_back());
                    pending_results.insert(pending_results.size(), stim_table[i].res);
                end
                maybe_gap();
            end
        end

        // full queue: port one stays empty while port zero overflows
        write_register(RegActive, 3'd2);
        write_register(RegFunction, FnAvg);
        for (int k = 0; k < 18; k++) send_item(CmdPush, 2'd0, 48'd100 + k, $urandom());
        send_item(CmdPush, 2'd1, 48'd200, $urandom());
        for (int p = 0; p < 4; p++) last_time[p] = 48'd200;

        // random phases with fresh settings each time
        items = 0;
        while (items < RandomItems) begin
            fn_pick = 3'($urandom_range(0, 7));
            write_register(RegFunction, fn_pick);
            case ($urandom_range(0, 9))
                0: write_register(RegActive, 3'd0);
                1: write_register(RegActive, 3'($urandom_range(5, 7)));
                default: write_register(RegActive, 3'($urandom_range(1, 4)));
            endcase
            n = (agg_active > 4) ? 4 : int'(agg_active);
            if ($urandom_range(0, 3) == 0)
                for (int p = 0; p < 4; p++) last_time[p] = 48'({$urandom(), $urandom()});
            for (int k = 0; k < 40; k++) begin
                no_gaps = (items >= 200 && items < 300);
                cmd = CmdPush;
                if (n == 0 || $urandom_range(0, 9) == 0) begin
                    // noise: any port, any time, and closes of the closed port
                    port = 2'($urandom_range(0, 3));
                    ts = 48'({$urandom(), $urandom()});
                    if ($urandom_range(0, 1) == 0) begin
                        cmd = CmdClose;
                        port = 2'd3;
                    end
                end else begin
                    port = 2'($urandom_range(0, n - 1));
                    ts = last_time[port] + 48'($urandom_range(0, 2));
                    last_time[port] = ts;
                end
                case ($urandom_range(0, 7))
                    0: val = PositiveInfinity;
                    1: val = NegativeInfinity;
                    default: val = $urandom();
                endcase
                send_item(cmd, port, ts, val);
                items++;
                maybe_gap();
            end
        end

        // final flush: close everything, the last aggregate reports all finished
        write_register(RegActive, 3'd4);
        write_register(RegFunction, FnSum);
        send_item(CmdClose, 2'd0, '0, '0);
        maybe_gap();
        send_item(CmdClose, 2'd1, '0, '0);
        maybe_gap();
        send_item(CmdClose, 2'd2, '0, '0);

        start <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SettleCycles) @(posedge i_clk);
        if (error_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ===== timestamp_aligned_aggregator.f =====
hw/rtl/taa_pkg.sv
hw/rtl/taa_ram.sv
hw/rtl/taa_front.sv
hw/rtl/taa_back.sv
hw/rtl/timestamp_aligned_aggregator.sv
test/tb_timestamp_aligned_aggregator.sv
